/* rtl/ipfd_pkg.sv */
// shared constants, types and register codes of the pickup and face-down detector
package ipfd_pkg;

    // sample and filter format
    localparam int SAMPLE_BITS  = 16;
    localparam int LP_FRAC_BITS = 8;

    // port field widths
    localparam int IN_W  = 16;
    localparam int TS_W  = 32;
    localparam int MAG_W = 16;

    // lane widths
    localparam int LP_W    = SAMPLE_BITS + LP_FRAC_BITS + 1;
    localparam int SQ_W    = 2 * SAMPLE_BITS;
    localparam int DSQ_W   = 2 * LP_W;
    localparam int DSUM_W  = DSQ_W + 2;
    localparam int M2_W    = 2 * SAMPLE_BITS;
    localparam int ROOT_W  = M2_W / 2;

    // register widths
    localparam int DEV_THR_W  = 13;
    localparam int SUSTAIN_W  = 32;
    localparam int FACE_THR_W = 15;
    localparam int ONE_G_W    = 15;
    localparam int FALLBACK_W = 20;
    localparam int MAX_INT_W  = 32;

    // deviation compare against thr^2 scaled into the filter fraction
    localparam int THR2_W  = 2 * DEV_THR_W;
    localparam int THR2S_W = THR2_W + 2 * LP_FRAC_BITS;
    localparam int DCMP_W  = (DSUM_W > THR2S_W) ? DSUM_W : THR2S_W;

    // magnitude against one g plus or minus threshold
    localparam int GG_W    = 2 * ONE_G_W;
    localparam int G_SUM_W = ONE_G_W + 1;
    localparam int GHI2_W  = 2 * G_SUM_W;
    localparam int GLO2_W  = 2 * ONE_G_W;
    localparam int MCMP_W  = (M2_W > GHI2_W) ? M2_W : GHI2_W;

    // tiny-sample drop: only m2 below 2^DROP_SHIFT can pass 1e6 * m2 < g^2
    localparam int DROP_SHIFT   = 11;
    localparam int DROP_SCALE_W = 20;
    localparam int DROP_PROD_W  = DROP_SHIFT + DROP_SCALE_W;
    localparam logic [DROP_SCALE_W-1:0] DROP_SCALE = DROP_SCALE_W'(1000000);

    // face-down test: az^2 * 2^30 > thr_q15^2 * m2
    localparam int FF_W       = 2 * FACE_THR_W;
    localparam int FACE_SHIFT = 2 * FACE_THR_W;
    localparam int FPROD_W    = FF_W + M2_W;
    localparam int FLHS_W     = SQ_W + FACE_SHIFT;
    localparam int FCMP_W     = (FLHS_W > FPROD_W) ? FLHS_W : FPROD_W;

    // configuration port
    localparam int ADDR_W    = 5;
    localparam int DATA_W    = 32;
    localparam int REG_IDX_W = 3;

    localparam logic [REG_IDX_W-1:0] REG_DEV_THR  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_SUSTAIN  = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_FACE_THR = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_ONE_G    = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_FALLBACK = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_MAX_INT  = 3'd5;

    // register reset values
    localparam logic [DEV_THR_W-1:0]  RST_DEV_THR  = 13'd1475;
    localparam logic [SUSTAIN_W-1:0]  RST_SUSTAIN  = 32'd120000;
    localparam logic [FACE_THR_W-1:0] RST_FACE_THR = 15'd26214;
    localparam logic [ONE_G_W-1:0]    RST_ONE_G    = 15'd8192;
    localparam logic [FALLBACK_W-1:0] RST_FALLBACK = 20'd50000;
    localparam logic [MAX_INT_W-1:0]  RST_MAX_INT  = 32'd1000000;

    typedef struct packed {
        logic [DEV_THR_W-1:0]  dev_thr;
        logic [SUSTAIN_W-1:0]  sustain;
        logic [FACE_THR_W-1:0] face_thr;
        logic [ONE_G_W-1:0]    one_g;
        logic [FALLBACK_W-1:0] fallback;
        logic [MAX_INT_W-1:0]  max_int;
    } t_cfg;

    // step strobes from the sequencer to lanes and merge
    typedef struct packed {
        logic step1;
        logic step2;
        logic step3;
        logic commit;
    } t_step;

    // findings of the merge stage
    typedef struct packed {
        logic drop;
        logic moving;
        logic face;
    } t_verdict;

endpackage

/* rtl/ipfd_lane.sv */
// one axis lane: sample square, low-pass update and squared deviation
module ipfd_lane (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  ipfd_pkg::t_step                       i_step,
    input  logic                                  i_lp_valid,
    input  logic signed [ipfd_pkg::SAMPLE_BITS-1:0] i_sample,
    output logic [ipfd_pkg::SQ_W-1:0]             o_sq,
    output logic [ipfd_pkg::DSQ_W-1:0]            o_dev_sq
);
    import ipfd_pkg::*;

    logic signed [LP_W-1:0]  r_lp;
    logic signed [LP_W-1:0]  r_lpn;
    logic signed [LP_W-1:0]  n_lpn;
    logic signed [LP_W-1:0]  w_x;
    logic signed [LP_W-1:0]  w_base;
    logic signed [LP_W:0]    w_diff;
    logic signed [LP_W:0]    w_dev;
    logic [LP_W-1:0]         r_ad;
    logic [LP_W-1:0]         n_ad;
    logic [SAMPLE_BITS-1:0]  w_abs;
    logic [SQ_W-1:0]         r_sq;
    logic [DSQ_W-1:0]        r_dsq;

    // filter step: seed on first sample, then lp += floor((x - lp) / 4)
    always_comb begin
        w_abs  = i_sample[SAMPLE_BITS-1] ? SAMPLE_BITS'(~i_sample + 1'b1)
                                         : SAMPLE_BITS'(i_sample);
        w_x    = LP_W'(i_sample) <<< LP_FRAC_BITS;
        w_base = i_lp_valid ? r_lp : w_x;
        w_diff = (LP_W + 1)'(w_x) - (LP_W + 1)'(w_base);
        n_lpn  = w_base + LP_W'(w_diff >>> 2);
        w_dev  = (LP_W + 1)'(w_x) - (LP_W + 1)'(n_lpn);
        n_ad   = w_dev[LP_W] ? LP_W'(-w_dev) : LP_W'(w_dev);
    end

    // filter state, written only once the sample is known to be kept
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lp <= '0;
        end else if (i_step.commit) begin
            r_lp <= r_lpn;
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (i_step.step1) begin
            r_sq  <= SQ_W'(w_abs) * SQ_W'(w_abs);
            r_lpn <= n_lpn;
            r_ad  <= n_ad;
        end
        if (i_step.step2) begin
            r_dsq <= DSQ_W'(r_ad) * DSQ_W'(r_ad);
        end
    end

    assign o_sq     = r_sq;
    assign o_dev_sq = r_dsq;

endmodule

/* rtl/ipfd_merge.sv */
// merge of the three lanes: vector length squared, drop, motion and face tests
module ipfd_merge (
    input  logic                         i_clk,
    input  ipfd_pkg::t_step              i_step,
    input  ipfd_pkg::t_cfg               i_cfg,
    input  logic [ipfd_pkg::SQ_W-1:0]    i_sq [3],
    input  logic [ipfd_pkg::DSQ_W-1:0]   i_dev_sq [3],
    input  logic                         i_z_pos,
    output logic [ipfd_pkg::M2_W-1:0]    o_m2,
    output ipfd_pkg::t_verdict           o_verdict
);
    import ipfd_pkg::*;

    logic [GG_W-1:0]        r_gg;
    logic [GHI2_W-1:0]      r_ghi2;
    logic [GLO2_W-1:0]      r_glo2;
    logic                   r_g_gt_thr;
    logic [THR2_W-1:0]      r_thr2;
    logic [FF_W-1:0]        r_ff;
    logic [M2_W-1:0]        r_m2;
    logic [DSUM_W-1:0]      r_dsum;
    logic                   r_drop;
    logic                   r_mag_move;
    logic [FPROD_W-1:0]     r_face_rhs;
    logic [G_SUM_W-1:0]     w_g_sum;
    logic [ONE_G_W-1:0]     w_g_diff;
    logic [ONE_G_W-1:0]     w_thr_g;
    logic [DROP_PROD_W-1:0] w_drop_prod;
    logic                   w_m2_small;

    always_comb begin
        w_thr_g     = ONE_G_W'(i_cfg.dev_thr);
        w_g_sum     = G_SUM_W'(i_cfg.one_g) + G_SUM_W'(i_cfg.dev_thr);
        w_g_diff    = i_cfg.one_g - w_thr_g;
        w_m2_small  = (r_m2 >> DROP_SHIFT) == '0;
        w_drop_prod = DROP_PROD_W'(r_m2[DROP_SHIFT-1:0]) * DROP_PROD_W'(DROP_SCALE);
    end

    // threshold products from the registers, vector length squared and the step-three findings
    always_ff @(posedge i_clk) begin
        if (i_step.step1) begin
            r_gg       <= GG_W'(i_cfg.one_g) * GG_W'(i_cfg.one_g);
            r_ghi2     <= GHI2_W'(w_g_sum) * GHI2_W'(w_g_sum);
            r_glo2     <= GLO2_W'(w_g_diff) * GLO2_W'(w_g_diff);
            r_g_gt_thr <= i_cfg.one_g > w_thr_g;
            r_thr2     <= THR2_W'(i_cfg.dev_thr) * THR2_W'(i_cfg.dev_thr);
            r_ff       <= FF_W'(i_cfg.face_thr) * FF_W'(i_cfg.face_thr);
        end
        if (i_step.step2) begin
            r_m2 <= M2_W'(i_sq[0]) + M2_W'(i_sq[1]) + M2_W'(i_sq[2]);
        end
        if (i_step.step3) begin
            r_dsum     <= DSUM_W'(i_dev_sq[0]) + DSUM_W'(i_dev_sq[1])
                        + DSUM_W'(i_dev_sq[2]);
            r_drop     <= w_m2_small && (w_drop_prod < DROP_PROD_W'(r_gg));
            r_mag_move <= (MCMP_W'(r_m2) > MCMP_W'(r_ghi2))
                       || (r_g_gt_thr && (MCMP_W'(r_m2) < MCMP_W'(r_glo2)));
            r_face_rhs <= FPROD_W'(r_ff) * FPROD_W'(r_m2);
        end
    end

    // final compares, read in the decision cycle
    always_comb begin
        o_verdict.drop   = r_drop;
        o_verdict.moving = r_mag_move
                        || (DCMP_W'(r_dsum) > (DCMP_W'(r_thr2) << (2 * LP_FRAC_BITS)));
        o_verdict.face   = i_z_pos
                        && ((FCMP_W'(i_sq[2]) << FACE_SHIFT) > FCMP_W'(r_face_rhs));
    end

    assign o_m2 = r_m2;

endmodule

/* rtl/ipfd_isqrt.sv */
// bit-pair integer square root, one root bit per cycle
module ipfd_isqrt (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [ipfd_pkg::M2_W-1:0]   i_radicand,
    output logic                        o_done,
    output logic [ipfd_pkg::ROOT_W-1:0] o_root
);
    import ipfd_pkg::*;

    localparam int REM_W = ROOT_W + 1;
    localparam int CNT_W = $clog2(ROOT_W);

    logic [M2_W-1:0]   r_rad;
    logic [REM_W-1:0]  r_rem;
    logic [ROOT_W-1:0] r_root;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_run;
    logic              r_done;
    logic [REM_W+1:0]  w_rem_sh;
    logic [REM_W+1:0]  w_trial;
    logic              w_take;

    // trial subtract of (4 * root + 1)
    always_comb begin
        w_rem_sh = {r_rem, r_rad[M2_W-1 -: 2]};
        w_trial  = (REM_W + 2)'({r_root, 2'b01});
        w_take   = w_rem_sh >= w_trial;
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
        end else if (i_start) begin
            r_run  <= 1'b1;
            r_done <= 1'b0;
        end else if (r_run && (r_cnt == '0)) begin
            r_run  <= 1'b0;
            r_done <= 1'b1;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= i_radicand;
            r_rem  <= '0;
            r_root <= '0;
            r_cnt  <= CNT_W'(ROOT_W - 1);
        end else if (r_run) begin
            r_rad <= r_rad << 2;
            r_cnt <= r_cnt - 1'b1;
            if (w_take) begin
                r_rem  <= REM_W'(w_rem_sh - w_trial);
                r_root <= {r_root[ROOT_W-2:0], 1'b1};
            end else begin
                r_rem  <= REM_W'(w_rem_sh);
                r_root <= {r_root[ROOT_W-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

/* rtl/imu_pickup_face_down_detector.sv */
// top level: register file, sequencer, axis lanes, merge, root and result register
//
//  channel | handshake                          | beat
//  --------+------------------------------------+-----------------------------------------
//  in      | i_valid / o_stall                  | i_accel_x, i_accel_y, i_accel_z, i_timestamp_us
//  out     | o_valid / i_stall                  | o_lifted, o_screen_down, o_magnitude
//  config  | psel, penable, pwrite, pready      | paddr, pwdata, prdata
//
// A kept sample passes the lane and merge steps (ST_C1, ST_C2, ST_C3, ST_DEC), the square
// root in ST_ROOT (one root bit per cycle), the load of the result register and an idle
// state in which the next sample is taken. A dropped sample returns to idle from ST_DEC.
// i_rst_n is synchronous; it restores register defaults, clears the filter seed flag,
// last timestamp and motion time. The result register holds a beat under i_stall
// while the next sample is taken; the root waits only if that register is still full.
module imu_pickup_face_down_detector (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    // sample channel
    input  logic                                    i_valid,
    output logic                                    o_stall,
    input  logic signed [ipfd_pkg::IN_W-1:0]        i_accel_x,
    input  logic signed [ipfd_pkg::IN_W-1:0]        i_accel_y,
    input  logic signed [ipfd_pkg::IN_W-1:0]        i_accel_z,
    input  logic [ipfd_pkg::TS_W-1:0]               i_timestamp_us,
    // result channel
    output logic                                    o_valid,
    input  logic                                    i_stall,
    output logic                                    o_lifted,
    output logic                                    o_screen_down,
    output logic [ipfd_pkg::MAG_W-1:0]              o_magnitude,
    // configuration
    input  logic                                    psel,
    input  logic                                    penable,
    input  logic                                    pwrite,
    input  logic [ipfd_pkg::ADDR_W-1:0]             paddr,
    input  logic [ipfd_pkg::DATA_W-1:0]             pwdata,
    output logic [ipfd_pkg::DATA_W-1:0]             prdata,
    output logic                                    pready
);
    import ipfd_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_C1   = 3'd1;
    localparam logic [2:0] ST_C2   = 3'd2;
    localparam logic [2:0] ST_C3   = 3'd3;
    localparam logic [2:0] ST_DEC  = 3'd4;
    localparam logic [2:0] ST_ROOT = 3'd5;

    logic [2:0]                     r_state;
    logic [2:0]                     n_state;
    t_cfg                           r_cfg;
    logic signed [SAMPLE_BITS-1:0]  r_sample [3];
    logic [TS_W-1:0]                r_ts;
    logic [TS_W-1:0]                r_last_ts;
    logic                           r_lp_valid;
    logic [TS_W-1:0]                r_motion;
    logic [TS_W-1:0]                n_motion;
    logic [TS_W-1:0]                r_dt;
    logic [TS_W-1:0]                w_delta;
    logic [TS_W:0]                  w_motion_sum;
    logic                           r_face;
    logic                           r_o_valid;
    logic                           r_o_picked;
    logic                           r_o_face;
    logic [MAG_W-1:0]               r_o_mag;
    logic                           w_in_acc;
    logic                           w_cfg_wr;
    logic [REG_IDX_W-1:0]           w_reg_idx;
    logic                           w_out_free;
    logic                           w_load_out;
    t_step                          w_step;
    t_verdict                       w_verdict;
    logic [SQ_W-1:0]                w_sq [3];
    logic [DSQ_W-1:0]               w_dev_sq [3];
    logic [M2_W-1:0]                w_m2;
    logic                           w_root_done;
    logic [ROOT_W-1:0]              w_root;

    assign w_in_acc   = i_valid && !o_stall;
    assign w_cfg_wr   = psel && penable && pwrite && pready;
    assign w_reg_idx  = paddr[ADDR_W-1:2];
    assign w_out_free = !r_o_valid || !i_stall;
    assign w_load_out = (r_state == ST_ROOT) && w_root_done && w_out_free;

    // register file
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.dev_thr  <= RST_DEV_THR;
            r_cfg.sustain  <= RST_SUSTAIN;
            r_cfg.face_thr <= RST_FACE_THR;
            r_cfg.one_g    <= RST_ONE_G;
            r_cfg.fallback <= RST_FALLBACK;
            r_cfg.max_int  <= RST_MAX_INT;
        end else if (w_cfg_wr) begin
            case (w_reg_idx)
                REG_DEV_THR:  r_cfg.dev_thr  <= pwdata[DEV_THR_W-1:0];
                REG_SUSTAIN:  r_cfg.sustain  <= pwdata[SUSTAIN_W-1:0];
                REG_FACE_THR: r_cfg.face_thr <= pwdata[FACE_THR_W-1:0];
                REG_ONE_G:    r_cfg.one_g    <= pwdata[ONE_G_W-1:0];
                REG_FALLBACK: r_cfg.fallback <= pwdata[FALLBACK_W-1:0];
                REG_MAX_INT:  r_cfg.max_int  <= pwdata[MAX_INT_W-1:0];
                default: ;
            endcase
        end
    end

    // register read back
    always_comb begin
        case (w_reg_idx)
            REG_DEV_THR:  prdata = DATA_W'(r_cfg.dev_thr);
            REG_SUSTAIN:  prdata = DATA_W'(r_cfg.sustain);
            REG_FACE_THR: prdata = DATA_W'(r_cfg.face_thr);
            REG_ONE_G:    prdata = DATA_W'(r_cfg.one_g);
            REG_FALLBACK: prdata = DATA_W'(r_cfg.fallback);
            REG_MAX_INT:  prdata = DATA_W'(r_cfg.max_int);
            default:      prdata = '0;
        endcase
    end

    assign pready = 1'b1;

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (w_in_acc) n_state = ST_C1;
            ST_C1:   n_state = ST_C2;
            ST_C2:   n_state = ST_C3;
            ST_C3:   n_state = ST_DEC;
            ST_DEC:  n_state = w_verdict.drop ? ST_IDLE : ST_ROOT;
            ST_ROOT: if (w_load_out) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_stall = r_state != ST_IDLE;

    always_comb begin
        w_step.step1  = r_state == ST_C1;
        w_step.step2  = r_state == ST_C2;
        w_step.step3  = r_state == ST_C3;
        w_step.commit = (r_state == ST_DEC) && !w_verdict.drop;
    end

    // sample capture
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_sample[0] <= SAMPLE_BITS'(i_accel_x);
            r_sample[1] <= SAMPLE_BITS'(i_accel_y);
            r_sample[2] <= SAMPLE_BITS'(i_accel_z);
            r_ts        <= i_timestamp_us;
        end
    end

    // elapsed time with fallback for zero or overlong gaps
    assign w_delta = r_ts - r_last_ts;

    always_ff @(posedge i_clk) begin
        if (w_step.step1) begin
            r_dt <= ((w_delta == '0) || (w_delta > r_cfg.max_int))
                  ? TS_W'(r_cfg.fallback) : w_delta;
        end
    end

    // saturating motion time, cleared when a sample shows no motion
    always_comb begin
        w_motion_sum = (TS_W + 1)'(r_motion) + (TS_W + 1)'(r_dt);
        if (!w_verdict.moving) begin
            n_motion = '0;
        end else if (w_motion_sum[TS_W]) begin
            n_motion = '1;
        end else begin
            n_motion = w_motion_sum[TS_W-1:0];
        end
    end

    // state kept across samples
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_ts  <= '0;
            r_lp_valid <= 1'b0;
            r_motion   <= '0;
        end else if (w_step.commit) begin
            r_last_ts  <= r_ts;
            r_lp_valid <= 1'b1;
            r_motion   <= n_motion;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step.commit) begin
            r_face <= w_verdict.face;
        end
    end

    // axis lanes
    for (genvar g = 0; g < 3; g++) begin : g_lane
        ipfd_lane u_lane (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_step     (w_step),
            .i_lp_valid (r_lp_valid),
            .i_sample   (r_sample[g]),
            .o_sq       (w_sq[g]),
            .o_dev_sq   (w_dev_sq[g])
        );
    end

    // merge of lane findings
    ipfd_merge u_merge (
        .i_clk     (i_clk),
        .i_step    (w_step),
        .i_cfg     (r_cfg),
        .i_sq      (w_sq),
        .i_dev_sq  (w_dev_sq),
        .i_z_pos   (!r_sample[2][SAMPLE_BITS-1] && (r_sample[2] != '0)),
        .o_m2      (w_m2),
        .o_verdict (w_verdict)
    );

    // magnitude
    ipfd_isqrt u_isqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_step.commit),
        .i_radicand (w_m2),
        .o_done     (w_root_done),
        .o_root     (w_root)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_load_out) begin
            r_o_valid <= 1'b1;
        end else if (!i_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_o_picked <= r_motion > r_cfg.sustain;
            r_o_face   <= r_face;
            r_o_mag    <= MAG_W'(w_root);
        end
    end

    assign o_valid       = r_o_valid;
    assign o_lifted      = r_o_picked;
    assign o_screen_down = r_o_face;
    assign o_magnitude   = r_o_mag;

endmodule

/* rtl/ipfd_checker.sv */
// port-level checks on the detector, bound to the top level
module ipfd_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_valid,
    input logic                          o_stall,
    input logic                          o_valid,
    input logic                          i_stall,
    input logic                          o_lifted,
    input logic                          o_screen_down,
    input logic [ipfd_pkg::MAG_W-1:0]    o_magnitude
);
    import ipfd_pkg::*;

    // a held result beat keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_lifted)
            && $stable(o_screen_down) && $stable(o_magnitude))
        else $error("result beat changed while stalled");

    // an accepted sample keeps the block busy on the next cycle
    a_busy_after_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("block not busy after accepting a sample");

    // a new result only appears at the end of a busy period
    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(o_stall))
        else $error("result beat with no sample in progress");

    // vector length of a 16-bit triple never exceeds 56755 counts
    a_mag_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_magnitude <= MAG_W'(56755))
        else $error("magnitude out of range");

endmodule

bind imu_pickup_face_down_detector ipfd_checker u_ipfd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (i_valid),
    .o_stall       (o_stall),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .o_lifted      (o_lifted),
    .o_screen_down (o_screen_down),
    .o_magnitude   (o_magnitude)
);
